// ----- sv/tsrb_pkg.sv -----
package tsrb_pkg;

    localparam int MAX_ENTRIES_DEF = 16;
    localparam int STAMP_W         = 32;
    localparam int HANDLE_W        = 16;
    localparam int HOLD_DEPTH_W    = 4;
    localparam int PADDR_W         = 3;
    localparam int PDATA_W         = 32;

    localparam logic [HOLD_DEPTH_W-1:0] HOLD_DEPTH_RST = 4'd4;

    // command codes
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // register index (paddr word bit)
    localparam logic REG_HOLD_DEPTH = 1'b0;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input word, walk position = count
        logic rd_walk;   // read entry just below the next walk position
        logic shift;     // move read entry up one slot, step walk down
        logic insert;    // write new entry at walk position, count up
        logic rd_head;   // read earliest entry
        logic emit;      // load output register from read entry, drop head
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_flush;
        logic count_zero;
        logic pos_one;
        logic walk_gt;
        logic overflow;
        logic out_free;
        logic last_entry;
    } stat_t;

endpackage

// ----- sv/tsrb_ctrl.sv -----
module tsrb_ctrl
    import tsrb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_WALK     = 6'b000100,
        S_INSERT   = 6'b001000,
        S_HEAD     = 6'b010000,
        S_EMIT     = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_flush)
                begin
                    state_next = stat.count_zero ? S_IDLE : S_HEAD;
                end
                else if (stat.count_zero)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.rd_walk = 1'b1;
                    state_next  = S_WALK;
                end
            end
            S_WALK:
            begin
                // read data holds the entry below the walk position
                if (stat.walk_gt)
                begin
                    cmd.shift = 1'b1;
                    if (stat.pos_one)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        cmd.rd_walk = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = stat.overflow ? S_HEAD : S_IDLE;
            end
            S_HEAD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.is_flush && !stat.last_entry)
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/tsrb_dpath.sv -----
module tsrb_dpath
    import tsrb_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cmd_t                    cmd,
    output stat_t                   stat,
    input  logic [HOLD_DEPTH_W-1:0] hold_depth,
    input  logic                    command,
    input  logic [STAMP_W-1:0]      arrival_stamp,
    input  logic [HANDLE_W-1:0]     packet_handle,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [HANDLE_W-1:0]     out_handle,
    output logic [STAMP_W-1:0]      out_stamp,
    output logic                    last_of_run
);

    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int DW = (AW > HOLD_DEPTH_W) ? AW : HOLD_DEPTH_W;
    localparam logic [AW:0]   MAX_W    = (AW+1)'(MAX_ENTRIES);
    localparam logic [AW-1:0] LAST_IDX = AW'(MAX_ENTRIES - 1);
    localparam logic [DW-1:0] CAP_W    = DW'(MAX_ENTRIES - 1);

    typedef struct packed {
        logic [STAMP_W-1:0]  stamp;
        logic [HANDLE_W-1:0] handle;
    } entry_t;

    entry_t mem [MAX_ENTRIES];

    logic                flush_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [AW-1:0]       pos_reg;
    logic [AW-1:0]       pos_next;
    logic [AW-1:0]       count_reg;
    logic [AW-1:0]       head_reg;
    entry_t              rd_reg;
    logic                out_valid_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [STAMP_W-1:0]  out_stamp_reg;
    logic                last_reg;

    logic                re;
    logic [AW-1:0]       raddr;
    logic                we;
    logic [AW-1:0]       waddr;
    entry_t              wdata;
    logic [DW-1:0]       depth_eff;
    logic                out_free;

    // circular index: head plus offset, wrapped once
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [AW-1:0] o);
        logic [AW:0] s;
        s = {1'b0, h} + {1'b0, o};
        if (s >= MAX_W)
        begin
            s = s - MAX_W;
        end
        return s[AW-1:0];
    endfunction

    assign pos_next = cmd.shift ? pos_reg - AW'(1) : pos_reg;
    assign re       = cmd.rd_walk | cmd.rd_head;
    assign raddr    = cmd.rd_head ? head_reg : phys(head_reg, pos_next - AW'(1));
    assign we       = cmd.shift | cmd.insert;
    assign waddr    = phys(head_reg, pos_reg);
    assign wdata    = cmd.shift ? rd_reg : entry_t'{stamp: stamp_reg, handle: handle_reg};

    assign depth_eff = (DW'(hold_depth) > CAP_W) ? CAP_W : DW'(hold_depth);
    assign out_free  = !out_valid_reg || out_ready;

    assign stat.is_flush   = flush_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.pos_one    = (pos_reg == AW'(1));
    assign stat.walk_gt    = (rd_reg.stamp > stamp_reg);
    assign stat.overflow   = (DW'(count_reg) >= depth_eff);
    assign stat.out_free   = out_free;
    assign stat.last_entry = (count_reg == AW'(1));

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            flush_reg  <= (command == CMD_FLUSH);
            stamp_reg  <= arrival_stamp;
            handle_reg <= packet_handle;
        end
        if (cmd.emit)
        begin
            out_handle_reg <= rd_reg.handle;
            out_stamp_reg  <= rd_reg.stamp;
            last_reg       <= flush_reg ? (count_reg == AW'(1)) : 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                pos_reg <= count_reg;
            end
            else
            begin
                pos_reg <= pos_next;
            end

            if (cmd.insert)
            begin
                count_reg <= count_reg + AW'(1);
            end
            else if (cmd.emit)
            begin
                count_reg <= count_reg - AW'(1);
            end

            if (cmd.emit)
            begin
                head_reg <= (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_handle  = out_handle_reg;
    assign out_stamp   = out_stamp_reg;
    assign last_of_run = last_reg;

endmodule

// ----- sv/timestamp_reorder_buffer.sv -----
// channel   signals                                        direction
// -------   ---------------------------------------------  ---------
// input     in_valid/in_ready: command, arrival_stamp,     in
//           packet_handle
// output    out_valid/out_ready: out_handle, out_stamp,    out
//           last_of_run
// config    APB: psel, penable, pwrite, paddr, pwdata,     in/out
//           prdata, pready; hold_depth at byte address 0
//
// One word at a time. A push insertion-sorts its word, comparing held entries
// from the newest down (entry memory with one read and one write port, one
// compare a cycle), and releases the earliest entry if the count had reached
// hold_depth (capped at MAX_ENTRIES - 1). A flush releases every held entry.
// Reset clears the entry count, head pointer and state; entry memory is not
// cleared. A stalled output register holds the release step until it drains.
module timestamp_reorder_buffer
    import tsrb_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                command,
    input  logic [STAMP_W-1:0]  arrival_stamp,
    input  logic [HANDLE_W-1:0] packet_handle,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [HANDLE_W-1:0] out_handle,
    output logic [STAMP_W-1:0]  out_stamp,
    output logic                last_of_run,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    cmd_t  cmd;
    stat_t stat;

    logic [HOLD_DEPTH_W-1:0] hold_depth_reg;
    logic                    reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_HOLD_DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_depth_reg <= HOLD_DEPTH_RST;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            hold_depth_reg <= pwdata[HOLD_DEPTH_W-1:0];
        end
    end

    assign prdata = reg_sel ? PDATA_W'(hold_depth_reg) : '0;

    tsrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsrb_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .hold_depth    (hold_depth_reg),
        .command       (command),
        .arrival_stamp (arrival_stamp),
        .packet_handle (packet_handle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_handle    (out_handle),
        .out_stamp     (out_stamp),
        .last_of_run   (last_of_run)
    );

endmodule
